>>> design/pfcc_pkg.sv
`default_nettype none

package pfcc_pkg;

  // conversion selected by the format_mode register; code 7 has no conversion
  typedef enum logic [2:0] {
    MODE_565_X888  = 3'd0,
    MODE_565_8888  = 3'd1,
    MODE_4444_8888 = 3'd2,
    MODE_1555_8888 = 3'd3,
    MODE_888_565   = 3'd4,
    MODE_COPY32    = 3'd5,
    MODE_COPY16    = 3'd6
  } mode_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FORMAT_MODE   = 2'd0,
    REG_KEY_ENABLE    = 2'd1,
    REG_KEY_SIXTEEN   = 2'd2,
    REG_KEY_THIRTYTWO = 2'd3
  } cfg_reg_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  localparam logic [15:0] KeySixteenReset   = 16'h2000;
  localparam logic [31:0] KeyThirtytwoReset = 32'h0020_0000;
  localparam logic [7:0]  AlphaOpaque       = 8'hFF;
  localparam logic [6:0]  HalfRound         = 7'd127;

  // stage 1: registered source with its key match
  typedef struct packed {
    logic [31:0] src;
    mode_t       mode;
    logic        keyed;
  } s1_t;

  // stage 2: widened channels and narrowing numerators
  typedef struct packed {
    mode_t       mode;
    logic        keyed;
    logic [23:0] w565;
    logic [31:0] w4444;
    logic [23:0] w1555;
    logic        a1555;
    logic [12:0] xr;
    logic [13:0] xg;
    logic [12:0] xb;
    logic [23:0] src24;
    logic [15:0] p16;
  } s2_t;

  // stage 3: finished pixel
  typedef struct packed {
    logic [31:0] pixel;
    logic        wr;
  } s3_t;

  // rounded widening to 8 bits: round(v*255/31) as (v*527+23)>>6
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [14:0] t;
    t = {10'd0, v} * 15'd527 + 15'd23;
    widen5 = t[13:6];
  endfunction

  // round(v*255/63) as (v*259+33)>>6
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [14:0] t;
    t = {9'd0, v} * 15'd259 + 15'd33;
    widen6 = t[13:6];
  endfunction

  // 4 bits scale by exactly 17, so replication is exact
  function automatic logic [7:0] widen4(input logic [3:0] v);
    widen4 = {v, v};
  endfunction

  // floor(x / 255) for x below 64*255 without a divider
  function automatic logic [5:0] div255(input logic [13:0] x);
    logic [14:0] t;
    t = {1'b0, x} + {9'd0, x[13:8]} + 15'd1;
    div255 = t[13:8];
  endfunction

endpackage

`default_nettype wire

>>> design/pfcc_in_if.sv
`default_nettype none

interface pfcc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

`default_nettype wire

>>> design/pfcc_out_if.sv
`default_nettype none

interface pfcc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pixel;
  logic        write_enable;

  modport source (output valid, output result_pixel, output write_enable, input ready);
  modport sink   (input valid, input result_pixel, input write_enable, output ready);
endinterface

`default_nettype wire

>>> design/pfcc_key_stage.sv
`default_nettype none

module pfcc_key_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire logic [31:0]     src,
  input  wire pfcc_pkg::mode_t mode,
  input  wire logic            key_en,
  input  wire logic [15:0]     key16,
  input  wire logic [31:0]     key32,
  output pfcc_pkg::s1_t        s1_r,
  output logic                 s1_valid_r
);

  pfcc_pkg::s1_t s1_nxt;
  logic          wide_src;

  always_comb begin
    wide_src      = (mode == pfcc_pkg::MODE_888_565) || (mode == pfcc_pkg::MODE_COPY32);
    s1_nxt.src    = src;
    s1_nxt.mode   = mode;
    s1_nxt.keyed  = key_en && (wide_src ? (src == key32) : (src[15:0] == key16));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/pfcc_convert.sv
`default_nettype none

module pfcc_convert (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire pfcc_pkg::s1_t s1,
  input  wire logic          s1_valid,
  output pfcc_pkg::s3_t      s3_r,
  output logic               s3_valid_r
);

  pfcc_pkg::s2_t s2_r, s2_nxt;
  pfcc_pkg::s3_t s3_nxt;
  logic          s2_valid_r;
  logic [15:0]   p;
  logic [7:0]    cr, cg, cb;
  logic [5:0]    qr, qb;
  logic [4:0]    nr, nb;
  logic [5:0]    ng;
  logic [31:0]   res;
  logic          ok;

  // stage 2: widening and the rounded numerators 31*v+127, 63*v+127
  always_comb begin
    p              = s1.src[15:0];
    cr             = s1.src[23:16];
    cg             = s1.src[15:8];
    cb             = s1.src[7:0];
    s2_nxt.mode    = s1.mode;
    s2_nxt.keyed   = s1.keyed;
    s2_nxt.w565    = {pfcc_pkg::widen5(p[15:11]), pfcc_pkg::widen6(p[10:5]),
                      pfcc_pkg::widen5(p[4:0])};
    s2_nxt.w4444   = {pfcc_pkg::widen4(p[15:12]), pfcc_pkg::widen4(p[11:8]),
                      pfcc_pkg::widen4(p[7:4]), pfcc_pkg::widen4(p[3:0])};
    s2_nxt.w1555   = {pfcc_pkg::widen5(p[14:10]), pfcc_pkg::widen5(p[9:5]),
                      pfcc_pkg::widen5(p[4:0])};
    s2_nxt.a1555   = p[15];
    s2_nxt.xr      = ({cr, 5'd0} - {5'd0, cr}) + {6'd0, pfcc_pkg::HalfRound};
    s2_nxt.xg      = ({cg, 6'd0} - {6'd0, cg}) + {7'd0, pfcc_pkg::HalfRound};
    s2_nxt.xb      = ({cb, 5'd0} - {5'd0, cb}) + {6'd0, pfcc_pkg::HalfRound};
    s2_nxt.src24   = s1.src[23:0];
    s2_nxt.p16     = p;
  end

  // stage 3: divide by 255, select by mode, apply key
  always_comb begin
    qr  = pfcc_pkg::div255({1'b0, s2_r.xr});
    qb  = pfcc_pkg::div255({1'b0, s2_r.xb});
    nr  = qr[4:0];
    ng  = pfcc_pkg::div255(s2_r.xg);
    nb  = qb[4:0];
    ok  = 1'b1;
    res = '0;
    unique case (s2_r.mode)
      pfcc_pkg::MODE_565_X888:  res = {8'd0, s2_r.w565};
      pfcc_pkg::MODE_565_8888:  res = {pfcc_pkg::AlphaOpaque, s2_r.w565};
      pfcc_pkg::MODE_4444_8888: res = s2_r.w4444;
      pfcc_pkg::MODE_1555_8888: res = {{8{s2_r.a1555}}, s2_r.w1555};
      pfcc_pkg::MODE_888_565:   res = {16'd0, nr, ng, nb};
      pfcc_pkg::MODE_COPY32:    res = {8'd0, s2_r.src24};
      pfcc_pkg::MODE_COPY16:    res = {16'd0, s2_r.p16};
      default:                  ok  = 1'b0;
    endcase
    s3_nxt.wr    = ok && !s2_r.keyed;
    s3_nxt.pixel = s3_nxt.wr ? res : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

endmodule

`default_nettype wire

>>> design/pixel_format_convert_colorkey_unit.sv
`default_nettype none

// Pixel format converter with color keying. Each source pixel transfer
// yields exactly one result transfer: the pixel converted as format_mode
// selects (565 to X888 or 8888, 4444 or 1555 to 8888, 888 to 565, 32-bit
// copy masked to 24 bits, 16-bit copy), with write_enable low and a zero
// pixel when keying is on and the source equals the key for its width, or
// when the mode code is 7. One pixel is taken every clock unless the
// output stalls; each passes four register stages (key compare, channel
// widening and numerators, divide by 255 and mode select, output register)
// before it is offered on out_chan. The whole pipe advances together when
// the output register is empty or being taken, so in_chan.ready follows
// out_chan.ready. The user is to write registers through the cfg_ port
// only while no pixel is in flight; the block itself does not enforce it.

module pixel_format_convert_colorkey_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pfcc_in_if.sink                            in_chan,
  pfcc_out_if.source                         out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [pfcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [pfcc_pkg::CfgDataW-1:0] cfg_wdata
);

  // configuration registers
  pfcc_pkg::mode_t format_mode_r;
  logic            key_enable_r;
  logic [15:0]     key_sixteen_r;
  logic [31:0]     key_thirtytwo_r;

  // pipeline
  logic            adv;
  pfcc_pkg::s1_t   s1;
  logic            s1_valid;
  pfcc_pkg::s3_t   s3;
  logic            s3_valid;
  logic            out_valid_r;
  logic [31:0]     out_pixel_r;
  logic            out_wr_r;

  // register writes, bits above each width dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r   <= pfcc_pkg::MODE_565_X888;
      key_enable_r    <= 1'b0;
      key_sixteen_r   <= pfcc_pkg::KeySixteenReset;
      key_thirtytwo_r <= pfcc_pkg::KeyThirtytwoReset;
    end else if (cfg_we) begin
      unique case (pfcc_pkg::cfg_reg_t'(cfg_index))
        pfcc_pkg::REG_FORMAT_MODE:   format_mode_r   <= pfcc_pkg::mode_t'(cfg_wdata[2:0]);
        pfcc_pkg::REG_KEY_ENABLE:    key_enable_r    <= cfg_wdata[0];
        pfcc_pkg::REG_KEY_SIXTEEN:   key_sixteen_r   <= cfg_wdata[15:0];
        pfcc_pkg::REG_KEY_THIRTYTWO: key_thirtytwo_r <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves when the output slot is free or being drained
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  // stage 1: capture and key compare
  pfcc_key_stage u_key (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (in_chan.valid),
    .src        (in_chan.source_pixel),
    .mode       (format_mode_r),
    .key_en     (key_enable_r),
    .key16      (key_sixteen_r),
    .key32      (key_thirtytwo_r),
    .s1_r       (s1),
    .s1_valid_r (s1_valid)
  );

  // stages 2 and 3: channel arithmetic and mode select
  pfcc_convert u_conv (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .s1         (s1),
    .s1_valid   (s1_valid),
    .s3_r       (s3),
    .s3_valid_r (s3_valid)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= s3.pixel;
      out_wr_r    <= s3.wr;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_pixel = out_pixel_r;
  assign out_chan.write_enable = out_wr_r;

endmodule

`default_nettype wire

>>> bench/pixel_format_convert_colorkey_unit_tb.sv
module pixel_format_convert_colorkey_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // mode code 7 selects no conversion: zero pixel, write suppressed
  localparam logic [2:0] ModeNone = 3'd7;
  // register stages from input transfer to the result being offered
  localparam int PipeDepth = 4;
  // largest channel codes for the rounded rescale
  localparam int unsigned Max4 = 15;
  localparam int unsigned Max5 = 31;
  localparam int unsigned Max6 = 63;
  localparam int unsigned Max8 = 255;
  localparam int RandPhases = 12;
  localparam int PhaseItems = 92;

  typedef struct packed {
    logic [31:0] pixel;
    logic        wr;
  } pix_result_t;

  // directed stimulus: register values, source pixel, and a typed-in result
  // where it is obvious; other rows go through the predictor
  typedef struct {
    logic [31:0] mode_wd;
    logic [31:0] key_wd;
    logic [31:0] src;
    bit          typed;
    logic [31:0] want_pix;
    bit          want_wr;
  } preset_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pfcc_pkg::CfgIdxW-1:0] cfg_index;
  logic [pfcc_pkg::CfgDataW-1:0] cfg_wdata;

  pfcc_in_if  in_chan ();
  pfcc_out_if out_chan ();

  pixel_format_convert_colorkey_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // shadow copy of the configuration registers
  logic [2:0]  cur_mode;
  logic        cur_key_en;
  logic [15:0] cur_key16;
  logic [31:0] cur_key32;

  // converted pixels still owed by the block, oldest first
  pix_result_t pixels_due[$];
  int mismatch_count;
  int burst_left;

  preset_row_t preset_pixels[] = '{
    // reset configuration: 565 to X888, keying off
    '{32'(pfcc_pkg::MODE_565_X888), 32'd0, 32'h0000_0000, 1, 32'h0000_0000, 1},
    '{32'(pfcc_pkg::MODE_565_X888), 32'd0, 32'h0000_FFFF, 1, 32'h00FF_FFFF, 1},
    '{32'(pfcc_pkg::MODE_565_X888), 32'd0, 32'hFFFF_0000, 1, 32'h0000_0000, 1},
    '{32'(pfcc_pkg::MODE_565_X888), 32'd0, 32'h1234_5678, 0, 32'h0, 0},
    '{32'(pfcc_pkg::MODE_565_8888), 32'd0, 32'h0000_0000, 1, 32'hFF00_0000, 1},
    '{32'(pfcc_pkg::MODE_565_8888), 32'd0, 32'h0000_FFFF, 1, 32'hFFFF_FFFF, 1},
    '{32'(pfcc_pkg::MODE_4444_8888), 32'd0, 32'h0000_0000, 1, 32'h0000_0000, 1},
    '{32'(pfcc_pkg::MODE_4444_8888), 32'd0, 32'h0000_FFFF, 1, 32'hFFFF_FFFF, 1},
    '{32'(pfcc_pkg::MODE_4444_8888), 32'd0, 32'h1234_A5C7, 0, 32'h0, 0},
    '{32'(pfcc_pkg::MODE_1555_8888), 32'd0, 32'h0000_8000, 1, 32'hFF00_0000, 1},
    '{32'(pfcc_pkg::MODE_1555_8888), 32'd0, 32'h0000_7FFF, 1, 32'h00FF_FFFF, 1},
    '{32'(pfcc_pkg::MODE_888_565), 32'd0, 32'hFFFF_FFFF, 1, 32'h0000_FFFF, 1},
    '{32'(pfcc_pkg::MODE_888_565), 32'd0, 32'hFF00_0000, 1, 32'h0000_0000, 1},
    '{32'(pfcc_pkg::MODE_888_565), 32'd0, 32'h0080_8080, 0, 32'h0, 0},
    '{32'(pfcc_pkg::MODE_COPY32), 32'd0, 32'hFFFF_FFFF, 1, 32'h00FF_FFFF, 1},
    '{32'(pfcc_pkg::MODE_COPY16), 32'd0, 32'hFFFF_FFFF, 1, 32'h0000_FFFF, 1},
    // unused mode code: nothing written, key or not
    '{32'(ModeNone), 32'd0, 32'h1234_5678, 1, 32'h0000_0000, 0},
    // keying with the reset keys; 16-bit modes compare the low half only
    '{32'(pfcc_pkg::MODE_COPY16), 32'd1, 32'h0000_2000, 1, 32'h0000_0000, 0},
    '{32'(pfcc_pkg::MODE_COPY16), 32'd1, 32'hFFFF_2000, 1, 32'h0000_0000, 0},
    '{32'(pfcc_pkg::MODE_COPY16), 32'd1, 32'h0000_2001, 1, 32'h0000_2001, 1},
    '{32'(pfcc_pkg::MODE_COPY32), 32'd1, 32'h0020_0000, 1, 32'h0000_0000, 0},
    '{32'(pfcc_pkg::MODE_COPY32), 32'd1, 32'h0120_0000, 1, 32'h0020_0000, 1},
    '{32'(ModeNone), 32'd1, 32'h0000_2000, 1, 32'h0000_0000, 0},
    // bits above each register's width must be dropped
    '{{29'h1FFF_FFFF, pfcc_pkg::MODE_565_X888}, 32'hFFFF_FFFE, 32'h0000_2000, 0, 32'h0, 0}
  };

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // rounded rescale of one channel code from 0..in_max to 0..out_max
  function automatic int unsigned scale_chan(input int unsigned v, input int unsigned in_max,
                                             input int unsigned out_max);
    return (v * 2 * out_max + in_max) / (2 * in_max);
  endfunction

  function automatic logic [31:0] pack_argb(input int unsigned a, input int unsigned r,
                                            input int unsigned g, input int unsigned b);
    return {a[7:0], r[7:0], g[7:0], b[7:0]};
  endfunction

  function automatic logic [31:0] expand_565(input logic [15:0] p);
    return pack_argb(0, scale_chan(32'(p[15:11]), Max5, Max8),
                     scale_chan(32'(p[10:5]), Max6, Max8),
                     scale_chan(32'(p[4:0]), Max5, Max8));
  endfunction

  function automatic bit wide_source_mode();
    return (cur_mode == pfcc_pkg::MODE_888_565) || (cur_mode == pfcc_pkg::MODE_COPY32);
  endfunction

  // expected output for one source pixel under the shadow configuration
  function automatic pix_result_t convert_pixel(input logic [31:0] src);
    logic [15:0] p16;
    logic [31:0] conv;
    int unsigned r, g, b;
    bit keyed;
    bit known;
    p16 = src[15:0];
    conv = '0;
    known = 1;
    if (wide_source_mode()) keyed = cur_key_en && (src == cur_key32);
    else keyed = cur_key_en && (p16 == cur_key16);
    case (cur_mode)
      pfcc_pkg::MODE_565_X888: conv = expand_565(p16);
      pfcc_pkg::MODE_565_8888: conv = expand_565(p16) | {pfcc_pkg::AlphaOpaque, 24'd0};
      pfcc_pkg::MODE_4444_8888: begin
        conv = pack_argb(scale_chan(32'(p16[15:12]), Max4, Max8),
                         scale_chan(32'(p16[11:8]), Max4, Max8),
                         scale_chan(32'(p16[7:4]), Max4, Max8),
                         scale_chan(32'(p16[3:0]), Max4, Max8));
      end
      pfcc_pkg::MODE_1555_8888: begin
        conv = pack_argb(p16[15] ? Max8 : 0, scale_chan(32'(p16[14:10]), Max5, Max8),
                         scale_chan(32'(p16[9:5]), Max5, Max8),
                         scale_chan(32'(p16[4:0]), Max5, Max8));
      end
      pfcc_pkg::MODE_888_565: begin
        r = scale_chan(32'(src[23:16]), Max8, Max5);
        g = scale_chan(32'(src[15:8]), Max8, Max6);
        b = scale_chan(32'(src[7:0]), Max8, Max5);
        conv = {16'd0, r[4:0], g[5:0], b[4:0]};
      end
      pfcc_pkg::MODE_COPY32: conv = {8'd0, src[23:0]};
      pfcc_pkg::MODE_COPY16: conv = {16'd0, p16};
      default: known = 0;
    endcase
    if (!known || keyed) return '{pixel: 32'd0, wr: 1'b0};
    return '{pixel: conv, wr: 1'b1};
  endfunction

  // one register write; the shadow copy keeps only the register's width
  task automatic write_reg(input pfcc_pkg::cfg_reg_t idx, input logic [31:0] wd);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = wd;
    @(posedge clk);
    case (idx)
      pfcc_pkg::REG_FORMAT_MODE:   cur_mode = wd[2:0];
      pfcc_pkg::REG_KEY_ENABLE:    cur_key_en = wd[0];
      pfcc_pkg::REG_KEY_SIXTEEN:   cur_key16 = wd[15:0];
      pfcc_pkg::REG_KEY_THIRTYTWO: cur_key32 = wd;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // stop sending and let the pipe empty before touching registers
  task automatic settle_pipe();
    in_chan.valid = 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
    repeat (PipeDepth) @(negedge clk);
  endtask

  // present one pixel and hold it until the transfer, then note what is owed
  task automatic send_pixel(input logic [31:0] src, input bit typed, input pix_result_t want);
    in_chan.valid = 1'b1;
    in_chan.source_pixel = src;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    if (typed) pixels_due.push_back(want);
    else pixels_due.push_back(convert_pixel(src));
    @(negedge clk);
  endtask

  // bursts of back-to-back pixels with random idle gaps between them
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid = 1'b0;
        in_chan.source_pixel = $urandom;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // random source biased toward key hits, near misses and channel extremes
  function automatic logic [31:0] pick_source();
    logic [31:0] v;
    logic [31:0] hit;
    v = $urandom;
    hit = wide_source_mode() ? cur_key32 : {v[31:16], cur_key16};
    case ($urandom_range(0, 7))
      0: v = hit;
      1: v = hit ^ (32'd1 << $urandom_range(0, 31));
      2: v = ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0) ^ (32'd1 << $urandom_range(0, 31));
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // result side: stall on a pattern, picking a new random stall style after each run
  initial begin : receiver
    int style;
    int left;
    logic [7:0] pat;
    out_chan.ready = 1'b0;
    style = 0;
    left = 0;
    pat = 8'h01;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left = $urandom_range(16, 96);
        pat = 8'($urandom) | 8'h01;
      end
      left--;
      case (style)
        0: out_chan.ready = 1'b1;
        1: out_chan.ready = 1'($urandom_range(0, 1));
        2: begin
          out_chan.ready = pat[0];
          pat = {pat[0], pat[7:1]};
        end
        default: out_chan.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // every result transfer is matched against the oldest owed pixel
  always @(posedge clk) begin : check_results
    pix_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pixels_due.size() == 0) begin
        report_mismatch("unexpected result transfer, pixel", 32'd0, out_chan.result_pixel);
      end else begin
        want = pixels_due.pop_front();
        if (out_chan.result_pixel !== want.pixel)
          report_mismatch("result_pixel", want.pixel, out_chan.result_pixel);
        if (out_chan.write_enable !== want.wr)
          report_mismatch("write_enable", {31'd0, want.wr}, {31'd0, out_chan.write_enable});
      end
    end
  end

  // generous ceiling on the whole run
  initial begin
    #3_000_000;
    $display("pixel_format_convert_colorkey_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] junk;
    logic [2:0] mode_sel;
    logic [15:0] key16_sel;
    logic [31:0] key32_sel;
    bit en_sel;
    mismatch_count = 0;
    burst_left = 0;
    cur_mode = pfcc_pkg::MODE_565_X888;
    cur_key_en = 1'b0;
    cur_key16 = pfcc_pkg::KeySixteenReset;
    cur_key32 = pfcc_pkg::KeyThirtytwoReset;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pfcc_pkg::REG_FORMAT_MODE;
    cfg_wdata = '0;
    in_chan.valid = 1'b0;
    in_chan.source_pixel = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed rows; registers change only when a row asks for new values
    foreach (preset_pixels[i]) begin
      if (preset_pixels[i].mode_wd[2:0] != cur_mode ||
          preset_pixels[i].key_wd[0] != cur_key_en) begin
        settle_pipe();
        if (preset_pixels[i].mode_wd[2:0] != cur_mode)
          write_reg(pfcc_pkg::REG_FORMAT_MODE, preset_pixels[i].mode_wd);
        if (preset_pixels[i].key_wd[0] != cur_key_en)
          write_reg(pfcc_pkg::REG_KEY_ENABLE, preset_pixels[i].key_wd);
      end
      send_pixel(preset_pixels[i].src, preset_pixels[i].typed,
                 '{pixel: preset_pixels[i].want_pix, wr: preset_pixels[i].want_wr});
      pace_sender();
    end

    // random phases: each one a fresh setting, with junk in the unused bits
    for (int ph = 0; ph < RandPhases; ph++) begin
      settle_pipe();
      mode_sel = (ph < 8) ? 3'(ph) : 3'($urandom_range(0, 7));
      en_sel = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      key16_sel = (ph == 0) ? 16'hFFFF : (ph == 1) ? 16'h0000 : 16'($urandom);
      key32_sel = (ph == 0) ? 32'hFFFF_FFFF : (ph == 1) ? 32'd0 : $urandom;
      junk = $urandom;
      write_reg(pfcc_pkg::REG_FORMAT_MODE, {junk[31:3], mode_sel});
      junk = $urandom;
      write_reg(pfcc_pkg::REG_KEY_ENABLE, {junk[31:1], en_sel});
      junk = $urandom;
      write_reg(pfcc_pkg::REG_KEY_SIXTEEN, {junk[31:16], key16_sel});
      write_reg(pfcc_pkg::REG_KEY_THIRTYTWO, key32_sel);
      for (int n = 0; n < PhaseItems; n++) begin
        send_pixel(pick_source(), 0, '{pixel: 32'd0, wr: 1'b0});
        pace_sender();
      end
    end

    // drain, then keep waiting for anything stray before the verdict
    in_chan.valid = 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (2 * PipeDepth) @(posedge clk);
    if (mismatch_count == 0 && pixels_due.size() == 0) begin
      $display("pixel_format_convert_colorkey_unit verification clean");
    end else begin
      $display("pixel_format_convert_colorkey_unit verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pfcc_pkg.sv
design/pfcc_in_if.sv
design/pfcc_out_if.sv
design/pfcc_key_stage.sv
design/pfcc_convert.sv
design/pixel_format_convert_colorkey_unit.sv
bench/pixel_format_convert_colorkey_unit_tb.sv
